// ----- design/tfmi_pkg.sv -----
// Shared constants, command/status types for the tricubic field map interpolator.
package tfmi_pkg;

	localparam int GRID_NX     = 32;
	localparam int GRID_NY     = 32;
	localparam int GRID_NZ     = 32;
	localparam int GRID_POINTS = GRID_NX * GRID_NY * GRID_NZ;
	localparam int ADDR_W      = $clog2(GRID_POINTS);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] CFG_INV_SP_X = 3'd3;
	localparam logic [2:0] CFG_INV_SP_Y = 3'd4;
	localparam logic [2:0] CFG_INV_SP_Z = 3'd5;
	localparam logic [2:0] CFG_MIRROR   = 3'd6;

	typedef struct packed {
		logic       take;     // latch query, clear accumulators
		logic       load;     // write one grid point
		logic       mul_go;   // scale one axis into grid units
		logic       kern_go;  // evaluate one kernel weight
		logic       nb_go;    // issue one neighbour
		logic       finish;   // round, saturate, present result
		logic [5:0] idx;
	} tfmi_cmd_t;

	typedef struct packed {
		logic kern_busy;
		logic nb_busy;
		logic out_full;
	} tfmi_stat_t;

endpackage

// ----- design/tfmi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tfmi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/tfmi_ctrl.sv -----
// Sequencer for loads and for one query: axis scaling, kernel weights, neighbour sweep, result.
module tfmi_ctrl
	import tfmi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       action,
	output logic       in_ready,
	input  tfmi_stat_t stat,
	output tfmi_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_KERN  = 3'd2;
	localparam logic [2:0] ST_KWAIT = 3'd3;
	localparam logic [2:0] ST_NBR   = 3'd4;
	localparam logic [2:0] ST_NWAIT = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACT_QUERY) begin
						cmd.take = 1'b1;
						state_d  = ST_MUL;
						cnt_d    = '0;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_go = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd2) begin
					state_d = ST_KERN;
					cnt_d   = '0;
				end
			end
			ST_KERN: begin
				cmd.kern_go = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd11) begin
					state_d = ST_KWAIT;
				end
			end
			ST_KWAIT: begin
				if (!stat.kern_busy) begin
					state_d = ST_NBR;
					cnt_d   = '0;
				end
			end
			ST_NBR: begin
				cmd.nb_go = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					state_d = ST_NWAIT;
				end
			end
			ST_NWAIT: begin
				if (!stat.nb_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stat.out_full) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- design/tfmi_dpath.sv -----
// Datapath: config registers, grid memories, axis scaling, kernel and MAC pipelines.
module tfmi_dpath
	import tfmi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tfmi_cmd_t          cmd,
	output tfmi_stat_t         stat,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [4:0]         load_ix,
	input  logic [4:0]         load_iy,
	input  logic [4:0]         load_iz,
	input  logic signed [23:0] sample_bx,
	input  logic signed [23:0] sample_by,
	input  logic signed [23:0] sample_bz,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [23:0] field_x,
	output logic signed [23:0] field_y,
	output logic signed [23:0] field_z
);

	// configuration
	logic signed [31:0] org_x_q, org_y_q, org_z_q;
	logic [23:0]        inv_x_q, inv_y_q, inv_z_q;
	logic               mirror_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q  <= '0;
			org_y_q  <= '0;
			org_z_q  <= '0;
			inv_x_q  <= 24'd65536;
			inv_y_q  <= 24'd65536;
			inv_z_q  <= 24'd65536;
			mirror_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN_X: org_x_q  <= cfg_data;
				CFG_ORIGIN_Y: org_y_q  <= cfg_data;
				CFG_ORIGIN_Z: org_z_q  <= cfg_data;
				CFG_INV_SP_X: inv_x_q  <= cfg_data[23:0];
				CFG_INV_SP_Y: inv_y_q  <= cfg_data[23:0];
				CFG_INV_SP_Z: inv_z_q  <= cfg_data[23:0];
				CFG_MIRROR:   mirror_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// grid memories
	logic              ld_inside, ram_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [23:0]       rd_x, rd_y, rd_z;

	assign ld_inside = (32'(load_ix) < GRID_NX) && (32'(load_iy) < GRID_NY)
		&& (32'(load_iz) < GRID_NZ);
	assign ram_we = cmd.load && ld_inside;
	assign waddr  = ADDR_W'(ADDR_W'(load_ix) * ADDR_W'(GRID_NY * GRID_NZ)
		+ ADDR_W'(load_iy) * ADDR_W'(GRID_NZ) + ADDR_W'(load_iz));

	tfmi_ram #(.WIDTH(24), .DEPTH(GRID_POINTS)) u_ram_x (
		.clk, .we(ram_we), .waddr, .wdata(sample_bx), .raddr, .rdata(rd_x));
	tfmi_ram #(.WIDTH(24), .DEPTH(GRID_POINTS)) u_ram_y (
		.clk, .we(ram_we), .waddr, .wdata(sample_by), .raddr, .rdata(rd_y));
	tfmi_ram #(.WIDTH(24), .DEPTH(GRID_POINTS)) u_ram_z (
		.clk, .we(ram_we), .waddr, .wdata(sample_bz), .raddr, .rdata(rd_z));

	// query latch and axis scaling (one axis per cycle)
	logic signed [31:0] qx_q, qy_q, qz_q;
	logic signed [31:0] q_sel, o_sel;
	logic [23:0]        inv_sel;
	logic signed [32:0] dsub;
	logic signed [33:0] dabs;
	logic signed [58:0] uprod;
	logic signed [24:0] cell_x_q, cell_y_q, cell_z_q;
	logic [15:0]        t_x_q, t_y_q, t_z_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			qx_q <= query_x;
			qy_q <= query_y;
			qz_q <= query_z;
		end
	end

	always_comb begin
		case (cmd.idx[1:0])
			2'd0: begin q_sel = qx_q; o_sel = org_x_q; inv_sel = inv_x_q; end
			2'd1: begin q_sel = qy_q; o_sel = org_y_q; inv_sel = inv_y_q; end
			default: begin q_sel = qz_q; o_sel = org_z_q; inv_sel = inv_z_q; end
		endcase
		dsub  = $signed({q_sel[31], q_sel}) - $signed({o_sel[31], o_sel});
		dabs  = (mirror_q && dsub[32]) ? -$signed({dsub[32], dsub})
			: $signed({dsub[32], dsub});
		uprod = dabs * $signed({1'b0, inv_sel});
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			case (cmd.idx[1:0])
				2'd0: begin cell_x_q <= uprod[56:32]; t_x_q <= uprod[31:16]; end
				2'd1: begin cell_y_q <= uprod[56:32]; t_y_q <= uprod[31:16]; end
				default: begin cell_z_q <= uprod[56:32]; t_z_q <= uprod[31:16]; end
			endcase
		end
	end

	// kernel pipeline: z, z^2 -> z^3 -> polynomial and rounding
	logic [15:0]        t_sel;
	logic [17:0]        kz;
	logic               kv_s1, kv_s2;
	logic [3:0]         kidx_s1, kidx_s2;
	logic [17:0]        kz_s1, kz_s2;
	logic [35:0]        kz2_s1, kz2_s2;
	logic [53:0]        kz3_s2;
	logic signed [55:0] z3e, z2e, ze, kw, kwr;
	logic signed [17:0] kwgt;
	logic signed [17:0] wx_q [4];
	logic signed [17:0] wy_q [4];
	logic signed [17:0] wz_q [4];

	always_comb begin
		case (cmd.idx[3:2])
			2'd0: t_sel = t_x_q;
			2'd1: t_sel = t_y_q;
			default: t_sel = t_z_q;
		endcase
		case (cmd.idx[1:0])
			2'd0: kz = 18'd65536 + {2'b0, t_sel};
			2'd1: kz = {2'b0, t_sel};
			2'd2: kz = 18'd65536 - {2'b0, t_sel};
			default: kz = 18'd131072 - {2'b0, t_sel};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_s1 <= 1'b0;
			kv_s2 <= 1'b0;
		end else begin
			kv_s1 <= cmd.kern_go;
			kv_s2 <= kv_s1;
		end
	end

	always_ff @(posedge clk) begin
		kidx_s1 <= cmd.idx[3:0];
		kz_s1   <= kz;
		kz2_s1  <= kz * kz;
		kidx_s2 <= kidx_s1;
		kz_s2   <= kz_s1;
		kz2_s2  <= kz2_s1;
		kz3_s2  <= kz2_s1 * kz_s1;
	end

	// weight = round(2*K(z)*2^48 / 2^33), kernel times two keeps all terms integral
	always_comb begin
		z3e = $signed({2'b0, kz3_s2});
		z2e = $signed({20'b0, kz2_s2});
		ze  = $signed({38'b0, kz_s2});
		if (kz_s2 < 18'd65536) begin
			kw = 56'sd3 * z3e - 56'sd5 * (z2e <<< 16) + (56'sd1 <<< 49);
		end else begin
			kw = -z3e + 56'sd5 * (z2e <<< 16) - (ze <<< 35) + (56'sd1 <<< 50);
		end
		kwr  = (kw + (56'sd1 <<< 32)) >>> 33;
		kwgt = (kz_s2 >= 18'd131072) ? 18'sd0 : kwr[17:0];
	end

	always_ff @(posedge clk) begin
		if (kv_s2) begin
			case (kidx_s2[3:2])
				2'd0: wx_q[kidx_s2[1:0]] <= kwgt;
				2'd1: wy_q[kidx_s2[1:0]] <= kwgt;
				default: wz_q[kidx_s2[1:0]] <= kwgt;
			endcase
		end
	end

	// neighbour pipeline: issue/read -> weight product -> sample product -> accumulate
	logic signed [25:0] nix, niy, niz;
	logic               n_in;
	logic               nr_s1, nr_s2, nr_s3;
	logic               nv_s1, nv_s2, nv_s3;
	logic signed [35:0] pxy_s1;
	logic signed [17:0] wz_s1;
	logic signed [53:0] p_s2;
	logic signed [23:0] dx_s2, dy_s2, dz_s2;
	logic signed [53:0] pr;
	logic signed [19:0] wn;
	logic signed [43:0] mx_s3, my_s3, mz_s3;
	logic signed [49:0] acc_x_q, acc_y_q, acc_z_q;

	always_comb begin
		nix = $signed({cell_x_q[24], cell_x_q}) + $signed({24'b0, cmd.idx[5:4]}) - 26'sd1;
		niy = $signed({cell_y_q[24], cell_y_q}) + $signed({24'b0, cmd.idx[3:2]}) - 26'sd1;
		niz = $signed({cell_z_q[24], cell_z_q}) + $signed({24'b0, cmd.idx[1:0]}) - 26'sd1;
		n_in = !nix[25] && (nix < 26'(GRID_NX)) && !niy[25] && (niy < 26'(GRID_NY))
			&& !niz[25] && (niz < 26'(GRID_NZ));
		raddr = ADDR_W'(ADDR_W'(nix) * ADDR_W'(GRID_NY * GRID_NZ)
			+ ADDR_W'(niy) * ADDR_W'(GRID_NZ) + ADDR_W'(niz));
		pr = (p_s2 + (54'sd1 <<< 31)) >>> 32;
		wn = pr[19:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nr_s1 <= 1'b0;
			nr_s2 <= 1'b0;
			nr_s3 <= 1'b0;
			nv_s1 <= 1'b0;
			nv_s2 <= 1'b0;
			nv_s3 <= 1'b0;
		end else begin
			nr_s1 <= cmd.nb_go;
			nr_s2 <= nr_s1;
			nr_s3 <= nr_s2;
			nv_s1 <= cmd.nb_go && n_in;
			nv_s2 <= nv_s1;
			nv_s3 <= nv_s2;
		end
	end

	always_ff @(posedge clk) begin
		pxy_s1 <= wx_q[cmd.idx[5:4]] * wy_q[cmd.idx[3:2]];
		wz_s1  <= wz_q[cmd.idx[1:0]];
		p_s2   <= pxy_s1 * wz_s1;
		dx_s2  <= $signed(rd_x);
		dy_s2  <= $signed(rd_y);
		dz_s2  <= $signed(rd_z);
		mx_s3  <= dx_s2 * wn;
		my_s3  <= dy_s2 * wn;
		mz_s3  <= dz_s2 * wn;
		if (cmd.take) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else if (nv_s3) begin
			acc_x_q <= acc_x_q + 50'(mx_s3);
			acc_y_q <= acc_y_q + 50'(my_s3);
			acc_z_q <= acc_z_q + 50'(mz_s3);
		end
	end

	// result register
	function automatic logic signed [23:0] tfmi_finish(input logic signed [49:0] acc);
		logic signed [49:0] r;
		r = (acc + 50'sd32768) >>> 16;
		if (r > 50'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (r < -50'sd8388608) begin
			return 24'sh800000;
		end
		return r[23:0];
	endfunction

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			field_x <= tfmi_finish(acc_x_q);
			field_y <= tfmi_finish(acc_y_q);
			field_z <= tfmi_finish(acc_z_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.kern_busy = kv_s1 || kv_s2;
	assign stat.nb_busy   = nr_s1 || nr_s2 || nr_s3;
	assign stat.out_full  = out_valid_q;

endmodule

// ----- design/tricubic_field_map_interpolator_top.sv -----
// Top level of the tricubic (Keys cubic convolution) field map interpolator.
//
// Channels:
//   in  : in_valid/in_ready. action = load writes one grid point (Bx, By, Bz)
//         at (load_ix, load_iy, load_iz); action = query brings a point in
//         Q15.16 cm and yields one result. Loads outside the grid are dropped.
//   out : out_valid/out_ready, field_x/y/z in Q3.20 tesla, saturated.
//   cfg : cfg_valid/cfg_ready (always ready), cfg_index selects the register
//         (origin x/y/z, inverse spacing x/y/z, mirror mode), cfg_data is the
//         value. Write only while the block is idle.
// Sequence:
//   A load request is written while the block stays idle. A query request runs
//   axis scaling (one shared 34x25 multiplier), kernel weights (one pipelined
//   cubic evaluator), the neighbour sweep (one read per cycle from each of the
//   three grid RAMs) and a rounding step, one query at a time; the next
//   request is taken only once the query's result has been presented.
// Reset clears control state and config registers to their defaults; grid
//   contents are undefined until loaded.
// A stalled receiver holds the result in the output register; the block still
//   takes the next request and only waits before presenting a second result.
module tricubic_field_map_interpolator_top
	import tfmi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [4:0]         load_ix,
	input  logic [4:0]         load_iy,
	input  logic [4:0]         load_iz,
	input  logic signed [23:0] sample_bx,
	input  logic signed [23:0] sample_by,
	input  logic signed [23:0] sample_bz,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] field_x,
	output logic signed [23:0] field_y,
	output logic signed [23:0] field_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	tfmi_cmd_t  cmd;
	tfmi_stat_t stat;

	// config writes complete in the cycle they are offered
	assign cfg_ready = 1'b1;

	tfmi_ctrl u_ctrl (
		.clk,
		.arst_n,
		.in_valid,
		.action,
		.in_ready,
		.stat,
		.cmd
	);

	tfmi_dpath u_dpath (
		.clk,
		.arst_n,
		.cmd,
		.stat,
		.cfg_valid,
		.cfg_index,
		.cfg_data,
		.load_ix,
		.load_iy,
		.load_iz,
		.sample_bx,
		.sample_by,
		.sample_bz,
		.query_x,
		.query_y,
		.query_z,
		.out_ready,
		.out_valid,
		.field_x,
		.field_y,
		.field_z
	);

endmodule

// ----- design/tfmi_checker.sv -----
// Port-level checker for the interpolator top, bound into it.
module tfmi_checker
	import tfmi_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               action,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [23:0] field_x,
	input logic               cfg_ready
);

	// held result stays put while the receiver stalls (field_x is checked)
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_x))
		else $error("result dropped or changed under stall");

	// a query occupies the sequencer: no new request next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_QUERY |=> !in_ready)
		else $error("request taken while a query is in flight");

	// no result can appear right after a request
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result rose one cycle after request");

	a_cfg_ready: assert property (@(posedge clk) cfg_ready)
		else $error("config port not ready");

endmodule

bind tricubic_field_map_interpolator_top tfmi_checker u_tfmi_checker (
	.clk,
	.arst_n,
	.in_valid,
	.in_ready,
	.action,
	.out_valid,
	.out_ready,
	.field_x,
	.cfg_ready
);
